// File: rtl/lps_pkg.sv
// shared widths, constants and divider handshake types for the lane pid steering core
package lps_pkg;

    // datapath widths
    localparam int DIV_NW = 40;
    localparam int DIV_DW = 20;
    localparam int DIV_CW = 6;
    localparam int MUL_W  = 20;
    localparam int ACC_W  = 60;

    // fixed constants of the control law
    localparam logic [DIV_DW-1:0] US_PER_S   = 20'd1000000;
    localparam logic signed [19:0] ERR_MAX   = 20'sd524287;
    localparam logic signed [19:0] ERR_MIN   = -20'sd524288;
    localparam logic signed [22:0] SUM_LIMIT = 23'sd655360;

    // configuration register indexes
    localparam logic [2:0] REG_GAIN_P    = 3'd0;
    localparam logic [2:0] REG_GAIN_I    = 3'd1;
    localparam logic [2:0] REG_GAIN_D    = 3'd2;
    localparam logic [2:0] REG_MAX_TURN  = 3'd3;
    localparam logic [2:0] REG_CRUISE    = 3'd4;
    localparam logic [2:0] REG_STOP_AREA = 3'd5;
    localparam logic [2:0] REG_FRAME_W   = 3'd6;

    // divider request and response
    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quotient;
    } div_rsp_t;

endpackage

// File: rtl/lps_div.sv
// shared restoring divider, one quotient bit per cycle, rounds half away from zero
module lps_div import lps_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW-1:0] dvs_reg, dvs_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              fin_reg, fin_next;
    logic [DIV_DW:0]   rem_sh;
    logic [DIV_DW:0]   rem_sub;
    logic              fits;
    logic              rnd;

    // one trial subtraction
    assign rem_sh  = {rem_reg, quo_reg[DIV_NW-1]};
    assign fits    = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        fin_next = 1'b0;
        if (req.start) begin
            rem_next = '0;
            quo_next = req.dividend;
            dvs_next = req.divisor;
            cnt_next = DIV_CW'(DIV_NW - 1);
            run_next = 1'b1;
        end else if (run_reg) begin
            rem_next = fits ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
            quo_next = {quo_reg[DIV_NW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                run_next = 1'b0;
                fin_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
        end else begin
            run_reg <= run_next;
            fin_reg <= fin_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    // round up when the remainder is at least half the divisor
    assign rnd          = {rem_reg, 1'b0} >= {1'b0, dvs_reg};
    assign rsp.done     = fin_reg;
    assign rsp.quotient = quo_reg + {{(DIV_NW-1){1'b0}}, rnd};

endmodule

// File: rtl/lps_mul.sv
// shared unsigned multiplier with registered product
module lps_mul import lps_pkg::*; (
    input  logic                 aclk,
    input  logic [MUL_W-1:0]     mul_a,
    input  logic [MUL_W-1:0]     mul_b,
    output logic [2*MUL_W-1:0]   prod_reg
);

    // product register
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

endmodule

// File: rtl/lane_pid_steer_with_stop_latch_core.sv
// top level: lane pid steering with permanent stop latch, sequencer and datapath
// a halted or zero-dt frame goes from accept straight to the emit state
// a full pid frame uses the shared 40-step divider for error (skipped at zero
// frame width), integral step and derivative, plus the multiply chain
// a new word is accepted only while the sequencer is idle; one result may wait
// in the output register meanwhile; synchronous active-low reset clears state
// and loads the register defaults
module lane_pid_steer_with_stop_latch_core import lps_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [23:0] cfg_wdata,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // pylon_area[23:0], cross_x[37:24], elapsed_us[57:38]
    input  logic [1:0]  s_tuser,   // pylon_seen[0], cross_valid[1]
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // speed_cmd[14:0], turn_cmd[30:15]
    output logic        m_tuser    // halted[0]
);

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_ERR_WAIT = 16'h0002,
        S_SUM_MUL  = 16'h0004,
        S_SUM_GO   = 16'h0008,
        S_SUM_WAIT = 16'h0010,
        S_DER_MUL  = 16'h0020,
        S_DER_GO   = 16'h0040,
        S_DER_WAIT = 16'h0080,
        S_ACC_P    = 16'h0100,
        S_ACC_I    = 16'h0200,
        S_ACC_DLO  = 16'h0400,
        S_ACC_DHI  = 16'h0800,
        S_ACC_END  = 16'h1000,
        S_ABS      = 16'h2000,
        S_FINAL    = 16'h4000,
        S_EMIT     = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [15:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [14:0] max_turn_reg, cruise_reg;
    logic [23:0] stop_area_reg;
    logic [12:0] frame_w_reg;

    // controller state
    logic               stop_reg, stop_next;
    logic               have_reg, have_next;
    logic [13:0]        hx_reg, hx_next;
    logic signed [19:0] prev_reg, prev_next;
    logic signed [21:0] sum_reg, sum_next;

    // working registers
    logic [19:0]        us_reg, us_next;
    logic               nneg_reg, nneg_next;
    logic signed [19:0] err_reg, err_next;
    logic [39:0]        dmag_reg, dmag_next;
    logic               dneg_reg, dneg_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0]   amag_reg, amag_next;
    logic               aneg_reg, aneg_next;

    // pending result and output register
    logic [14:0]        res_speed_reg, res_speed_next;
    logic [15:0]        res_turn_reg, res_turn_next;
    logic               res_halt_reg, res_halt_next;
    logic               out_valid_reg, out_valid_next;
    logic [14:0]        out_speed_reg, out_speed_next;
    logic [15:0]        out_turn_reg, out_turn_next;
    logic               out_halt_reg, out_halt_next;

    // input fields
    logic        in_seen, in_cvalid;
    logic [23:0] in_area;
    logic [13:0] in_cx;
    logic [19:0] in_us;
    logic        accept;

    assign in_area   = s_tdata[23:0];
    assign in_cx     = s_tdata[37:24];
    assign in_us     = s_tdata[57:38];
    assign in_seen   = s_tuser[0];
    assign in_cvalid = s_tuser[1];
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;

    // shared units
    div_req_t           div_req;
    div_rsp_t           div_rsp;
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] prod_reg;

    lps_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    lps_mul u_mul (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_reg (prod_reg)
    );

    // offset numerator from the image center
    logic [13:0]        hx_eff;
    logic signed [15:0] ndiff;
    logic [15:0]        nmag;
    assign hx_eff = in_cvalid ? in_cx : hx_reg;
    assign ndiff  = $signed({1'b0, hx_eff, 1'b0}) - $signed({3'b000, frame_w_reg});
    assign nmag   = ndiff[15] ? 16'(-ndiff) : 16'(ndiff);

    // magnitudes fed to the multiplier
    logic [19:0]        err_mag;
    logic signed [20:0] ediff;
    logic [19:0]        ediff_mag;
    logic [21:0]        sum_abs;
    assign err_mag   = err_reg[19] ? 20'(-err_reg) : 20'(err_reg);
    assign ediff     = 21'(err_reg) - 21'(prev_reg);
    assign ediff_mag = ediff[20] ? 20'(-ediff) : ediff[19:0];
    assign sum_abs   = sum_reg[21] ? 22'(-sum_reg) : 22'(sum_reg);

    // integral step and clamp
    logic signed [22:0] sum_step, sum_raw;
    assign sum_step = $signed({3'b000, div_rsp.quotient[19:0]});
    assign sum_raw  = err_reg[19] ? 23'(sum_reg) - sum_step : 23'(sum_reg) + sum_step;

    // accumulator add or subtract of the current product
    logic [ACC_W-1:0] acc_term;
    logic             acc_neg;
    logic signed [ACC_W-1:0] acc_sum;
    assign acc_sum = acc_neg ? acc_reg - $signed(acc_term) : acc_reg + $signed(acc_term);

    // rounding to Q4.12 and turn clamp
    logic [ACC_W-1:0] amag_rnd;
    logic [ACC_W-17:0] turn_q;
    logic [14:0]      turn_mag;
    assign amag_rnd = amag_reg + ACC_W'(32768);
    assign turn_q   = amag_rnd[ACC_W-1:16];
    assign turn_mag = (turn_q > (ACC_W-16)'(max_turn_reg)) ? max_turn_reg : turn_q[14:0];

    // sequencer and datapath
    always_comb begin
        state_next     = state_reg;
        stop_next      = stop_reg;
        have_next      = have_reg;
        hx_next        = hx_reg;
        prev_next      = prev_reg;
        sum_next       = sum_reg;
        us_next        = us_reg;
        nneg_next      = nneg_reg;
        err_next       = err_reg;
        dmag_next      = dmag_reg;
        dneg_next      = dneg_reg;
        acc_next       = acc_reg;
        amag_next      = amag_reg;
        aneg_next      = aneg_reg;
        res_speed_next = res_speed_reg;
        res_turn_next  = res_turn_reg;
        res_halt_next  = res_halt_reg;
        div_req        = '0;
        mul_a          = '0;
        mul_b          = '0;
        acc_term       = '0;
        acc_neg        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (stop_reg || (in_seen && (in_area >= stop_area_reg))) begin
                        stop_next      = 1'b1;
                        res_speed_next = '0;
                        res_turn_next  = '0;
                        res_halt_next  = 1'b1;
                        state_next     = S_EMIT;
                    end else begin
                        if (in_cvalid) begin
                            hx_next   = in_cx;
                            have_next = 1'b1;
                        end
                        if (have_reg || in_cvalid) begin
                            us_next   = in_us;
                            nneg_next = ndiff[15];
                            if (in_us == '0) begin
                                res_speed_next = cruise_reg;
                                res_turn_next  = '0;
                                res_halt_next  = 1'b0;
                                state_next     = S_EMIT;
                            end else if (frame_w_reg == '0) begin
                                // no width: positive limit unless x is at zero
                                err_next   = (hx_eff != '0) ? ERR_MAX : '0;
                                state_next = S_SUM_MUL;
                            end else begin
                                div_req.start    = 1'b1;
                                div_req.dividend = DIV_NW'({nmag[14:0], 16'h0000});
                                div_req.divisor  = DIV_DW'(frame_w_reg);
                                state_next       = S_ERR_WAIT;
                            end
                        end
                    end
                end
            end
            S_ERR_WAIT: begin
                if (div_rsp.done) begin
                    if (nneg_reg) begin
                        err_next = (div_rsp.quotient > DIV_NW'(524288)) ? ERR_MIN
                                 : 20'(-div_rsp.quotient[19:0]);
                    end else begin
                        err_next = (div_rsp.quotient > DIV_NW'(524287)) ? ERR_MAX
                                 : $signed(div_rsp.quotient[19:0]);
                    end
                    state_next = S_SUM_MUL;
                end
            end
            S_SUM_MUL: begin
                mul_a      = err_mag;
                mul_b      = us_reg;
                state_next = S_SUM_GO;
            end
            S_SUM_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_reg;
                div_req.divisor  = US_PER_S;
                state_next       = S_SUM_WAIT;
            end
            S_SUM_WAIT: begin
                if (div_rsp.done) begin
                    if (sum_raw > SUM_LIMIT) begin
                        sum_next = 22'(SUM_LIMIT);
                    end else if (sum_raw < -SUM_LIMIT) begin
                        sum_next = 22'(-SUM_LIMIT);
                    end else begin
                        sum_next = sum_raw[21:0];
                    end
                    state_next = S_DER_MUL;
                end
            end
            S_DER_MUL: begin
                mul_a      = ediff_mag;
                mul_b      = US_PER_S;
                state_next = S_DER_GO;
            end
            S_DER_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_reg;
                div_req.divisor  = us_reg;
                state_next       = S_DER_WAIT;
            end
            S_DER_WAIT: begin
                if (div_rsp.done) begin
                    dmag_next  = div_rsp.quotient;
                    dneg_next  = ediff[20];
                    state_next = S_ACC_P;
                end
            end
            S_ACC_P: begin
                mul_a      = MUL_W'(gain_p_reg);
                mul_b      = err_mag;
                acc_next   = '0;
                state_next = S_ACC_I;
            end
            S_ACC_I: begin
                mul_a      = MUL_W'(gain_i_reg);
                mul_b      = sum_abs[19:0];
                acc_term   = ACC_W'(prod_reg);
                acc_neg    = err_reg[19];
                acc_next   = acc_sum;
                state_next = S_ACC_DLO;
            end
            S_ACC_DLO: begin
                mul_a      = MUL_W'(gain_d_reg);
                mul_b      = dmag_reg[19:0];
                acc_term   = ACC_W'(prod_reg);
                acc_neg    = sum_reg[21];
                acc_next   = acc_sum;
                state_next = S_ACC_DHI;
            end
            S_ACC_DHI: begin
                mul_a      = MUL_W'(gain_d_reg);
                mul_b      = dmag_reg[39:20];
                acc_term   = ACC_W'(prod_reg);
                acc_neg    = dneg_reg;
                acc_next   = acc_sum;
                state_next = S_ACC_END;
            end
            S_ACC_END: begin
                acc_term   = ACC_W'({prod_reg, 20'h00000});
                acc_neg    = dneg_reg;
                acc_next   = acc_sum;
                state_next = S_ABS;
            end
            S_ABS: begin
                aneg_next  = acc_reg[ACC_W-1];
                amag_next  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
                state_next = S_FINAL;
            end
            S_FINAL: begin
                // turn is the negated pid output
                res_turn_next  = aneg_reg ? {1'b0, turn_mag} : 16'(-{1'b0, turn_mag});
                res_speed_next = cruise_reg;
                res_halt_next  = 1'b0;
                prev_next      = err_reg;
                state_next     = S_EMIT;
            end
            S_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_speed_next = out_speed_reg;
        out_turn_next  = out_turn_reg;
        out_halt_next  = out_halt_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == S_EMIT) && (!out_valid_reg || m_tready)) begin
            out_valid_next = 1'b1;
            out_speed_next = res_speed_reg;
            out_turn_next  = res_turn_reg;
            out_halt_next  = res_halt_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_turn_reg, out_speed_reg};
    assign m_tuser  = out_halt_reg;

    // control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            stop_reg      <= 1'b0;
            have_reg      <= 1'b0;
            hx_reg        <= '0;
            prev_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            gain_p_reg    <= 16'd4096;
            gain_i_reg    <= 16'd410;
            gain_d_reg    <= 16'd205;
            max_turn_reg  <= 15'd4096;
            cruise_reg    <= 15'd4096;
            stop_area_reg <= 24'd10000;
            frame_w_reg   <= 13'd640;
        end else begin
            state_reg     <= state_next;
            stop_reg      <= stop_next;
            have_reg      <= have_next;
            hx_reg        <= hx_next;
            prev_reg      <= prev_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_GAIN_P:    gain_p_reg    <= cfg_wdata[15:0];
                    REG_GAIN_I:    gain_i_reg    <= cfg_wdata[15:0];
                    REG_GAIN_D:    gain_d_reg    <= cfg_wdata[15:0];
                    REG_MAX_TURN:  max_turn_reg  <= cfg_wdata[14:0];
                    REG_CRUISE:    cruise_reg    <= cfg_wdata[14:0];
                    REG_STOP_AREA: stop_area_reg <= cfg_wdata[23:0];
                    REG_FRAME_W:   frame_w_reg   <= cfg_wdata[12:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        us_reg        <= us_next;
        nneg_reg      <= nneg_next;
        err_reg       <= err_next;
        dmag_reg      <= dmag_next;
        dneg_reg      <= dneg_next;
        acc_reg       <= acc_next;
        amag_reg      <= amag_next;
        aneg_reg      <= aneg_next;
        res_speed_reg <= res_speed_next;
        res_turn_reg  <= res_turn_next;
        res_halt_reg  <= res_halt_next;
        out_speed_reg <= out_speed_next;
        out_turn_reg  <= out_turn_next;
        out_halt_reg  <= out_halt_next;
    end

endmodule
